[sv/acm_pkg.sv]
`default_nettype none

package acm_pkg;

   localparam int BYTE_W           = 8;
   localparam int SIZE_W           = 9;
   localparam int FUNC_W           = 3;
   localparam int TABLE_DEPTH      = 256;
   localparam int SYMBOL_COUNT_DEF = 256;

   localparam logic [BYTE_W-1:0] MISS_CODE = 8'hFF;
   localparam logic [BYTE_W-1:0] LAST_BYTE = 8'hFF;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_BUILD = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MAP   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_UNMAP = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic build_step;
      logic load_rsp;
   } acm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic build_done;
      logic out_free;
   } acm_status_type;

endpackage

`default_nettype wire

[sv/acm_if.sv]
`default_nettype none

interface acm_req_if;
   import acm_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [BYTE_W-1:0] value;
   logic              last;

   modport source (output valid, func, value, last, input ready);
   modport sink   (input valid, func, value, last, output ready);
endinterface

interface acm_rsp_if;
   import acm_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] result;
   logic              miss;
   logic [SIZE_W-1:0] alphabet_size;
   logic              last_out;

   modport source (output valid, result, miss, alphabet_size, last_out, input ready);
   modport sink   (input valid, result, miss, alphabet_size, last_out, output ready);
endinterface

`default_nettype wire

[sv/acm_ctrl.sv]
`default_nettype none

module acm_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [acm_pkg::FUNC_W-1:0]  req_func,
   output logic                             req_ready,
   input  wire acm_pkg::acm_status_type     status,
   output acm_pkg::acm_cmd_type             cmd
);
   import acm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_BUILD  = 3'b010,
      ST_RESULT = 3'b100
   } acm_state_type;

   acm_state_type state_ff;
   acm_state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // sequence one beat at a time: accept, optional table walk, result load
   always_comb begin
      state_in       = state_ff;
      cmd.accept     = 1'b0;
      cmd.build_step = 1'b0;
      cmd.load_rsp   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_func == FUNC_BUILD) ? ST_BUILD : ST_RESULT;
            end
         end
         ST_BUILD: begin
            cmd.build_step = 1'b1;
            if (status.build_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[sv/acm_datapath.sv]
`default_nettype none

module acm_datapath #(
   parameter int SYMBOL_COUNT = acm_pkg::SYMBOL_COUNT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire acm_pkg::acm_cmd_type        cmd,
   output acm_pkg::acm_status_type          status,
   input  wire logic [acm_pkg::FUNC_W-1:0]  req_func,
   input  wire logic [acm_pkg::BYTE_W-1:0]  req_value,
   input  wire logic                        req_last,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [acm_pkg::BYTE_W-1:0]       rsp_result,
   output logic                             rsp_miss,
   output logic [acm_pkg::SIZE_W-1:0]       rsp_alphabet_size,
   output logic                             rsp_last_out
);
   import acm_pkg::*;

   localparam int PRES_AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam logic [SIZE_W-1:0] SYM_LIMIT = SIZE_W'(SYMBOL_COUNT);

   // presence flags, cleared at once
   logic [SYMBOL_COUNT-1:0] present_ff;
   logic [SYMBOL_COUNT-1:0] present_in;

   // forward and reverse tables
   logic [BYTE_W-1:0] fwd_mem [TABLE_DEPTH];
   logic [BYTE_W-1:0] rev_mem [TABLE_DEPTH];
   logic [BYTE_W-1:0] fwd_rd_ff;
   logic [BYTE_W-1:0] rev_rd_ff;

   // latched request
   logic [FUNC_W-1:0] func_ff;
   logic [BYTE_W-1:0] value_ff;
   logic              last_ff;

   // build walk
   logic [BYTE_W-1:0] idx_ff;
   logic [BYTE_W-1:0] idx_in;
   logic [SIZE_W-1:0] rank_ff;
   logic [SIZE_W-1:0] rank_in;
   logic              walk_hit;

   // alphabet state
   logic [SIZE_W-1:0] total_ff;
   logic [SIZE_W-1:0] total_in;
   logic              ready_ff;
   logic              ready_in;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] result_ff;
   logic              miss_ff;
   logic [SIZE_W-1:0] size_ff;
   logic              last_out_ff;
   logic [BYTE_W-1:0] result_in;
   logic              miss_in;

   // update presence on clear and add
   always_comb begin
      present_in = present_ff;
      if (cmd.accept) begin
         if (req_func == FUNC_CLEAR) begin
            present_in = '0;
         end else if (req_func == FUNC_ADD && {1'b0, req_value} < SYM_LIMIT) begin
            present_in[req_value[PRES_AW-1:0]] = 1'b1;
         end
      end
   end

   // walk one byte value per cycle during build
   always_comb begin
      walk_hit = ({1'b0, idx_ff} < SYM_LIMIT) && present_ff[idx_ff[PRES_AW-1:0]];
      idx_in   = idx_ff;
      rank_in  = rank_ff;
      total_in = total_ff;
      ready_in = ready_ff;
      if (cmd.accept) begin
         idx_in  = '0;
         rank_in = '0;
      end else if (cmd.build_step) begin
         idx_in  = idx_ff + 1'b1;
         rank_in = rank_ff + SIZE_W'(walk_hit);
         if (status.build_done) begin
            total_in = rank_ff + SIZE_W'(walk_hit);
            ready_in = 1'b1;
         end
      end
   end

   assign status.build_done = (idx_ff == LAST_BYTE);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // table writes during the walk
   always_ff @(posedge clock) begin
      if (cmd.build_step) begin
         fwd_mem[idx_ff] <= walk_hit ? rank_ff[BYTE_W-1:0] : MISS_CODE;
         if (walk_hit) begin
            rev_mem[rank_ff[BYTE_W-1:0]] <= idx_ff;
         end
      end
   end

   // table reads on accept
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         fwd_rd_ff <= fwd_mem[req_value];
         rev_rd_ff <= rev_mem[req_value];
      end
   end

   // form the answer from the latched beat
   always_comb begin
      result_in = '0;
      miss_in   = 1'b0;
      case (func_ff)
         FUNC_MAP: begin
            if (!ready_ff || {1'b0, fwd_rd_ff} >= total_ff) begin
               result_in = MISS_CODE;
               miss_in   = 1'b1;
            end else begin
               result_in = fwd_rd_ff;
            end
         end
         FUNC_UNMAP: begin
            if (!ready_ff || {1'b0, value_ff} >= total_ff) begin
               result_in = MISS_CODE;
               miss_in   = 1'b1;
            end else begin
               result_in = rev_rd_ff;
            end
         end
         default: begin
            result_in = '0;
            miss_in   = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         total_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         present_ff   <= present_in;
         total_ff     <= total_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      rank_ff <= rank_in;
      if (cmd.accept) begin
         func_ff  <= req_func;
         value_ff <= req_value;
         last_ff  <= req_last;
      end
      if (cmd.load_rsp) begin
         result_ff   <= result_in;
         miss_ff     <= miss_in;
         size_ff     <= total_ff;
         last_out_ff <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result        = result_ff;
   assign rsp_miss          = miss_ff;
   assign rsp_alphabet_size = size_ff;
   assign rsp_last_out      = last_out_ff;

endmodule

`default_nettype wire

[sv/alphabet_compaction_mapper_top.sv]
`default_nettype none

// Dense alphabet mapper. Each request beat carries a function: clear empties
// the set of present bytes, add marks one byte present, build assigns every
// present byte its rank in ascending byte order and fills a byte-to-code and
// a code-to-byte table, map turns a byte into its code and unmap a code into
// its byte (255 with miss set when the byte is absent, the code is at or
// above the alphabet size, or no build has run yet). Every request gives
// exactly one response beat, which also reports the alphabet size of the
// last build and echoes last. The block holds one request at a time: clear,
// add, map and unmap pass through accept (which also registers the table
// read) and the result load, and build through accept, a walk over all table
// entries one per cycle through each table's single write port, and the result
// load; the result load waits until the output register is free. The response
// sits in an output register, so a new request is taken while it waits.
module alphabet_compaction_mapper_top #(
   parameter int SYMBOL_COUNT = acm_pkg::SYMBOL_COUNT_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   acm_req_if.sink    req_chan,
   acm_rsp_if.source  rsp_chan
);
   import acm_pkg::*;

   acm_cmd_type    cmd;
   acm_status_type status;

   acm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   acm_datapath #(
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_chan.func),
      .req_value         (req_chan.value),
      .req_last          (req_chan.last),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_result        (rsp_chan.result),
      .rsp_miss          (rsp_chan.miss),
      .rsp_alphabet_size (rsp_chan.alphabet_size),
      .rsp_last_out      (rsp_chan.last_out)
   );

endmodule

`default_nettype wire

[sv/acm_checker.sv]
`default_nettype none

module acm_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [acm_pkg::BYTE_W-1:0]  rsp_result,
   input wire logic                        rsp_miss,
   input wire logic [acm_pkg::SIZE_W-1:0]  rsp_alphabet_size
);
   import acm_pkg::*;

   // hold a response beat until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped before it was taken");

   // a miss always reports the miss code
   a_miss_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_miss |-> rsp_result == MISS_CODE)
      else $error("miss without miss code");

   // an empty alphabet answers nothing but a miss or zero
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alphabet_size == '0 |-> rsp_miss || rsp_result == '0)
      else $error("hit reported with empty alphabet");

   // the alphabet never exceeds the byte range
   a_size_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alphabet_size <= SIZE_W'(TABLE_DEPTH))
      else $error("alphabet size out of range");

   // one request in flight: no accept right after an accept
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

endmodule

bind alphabet_compaction_mapper_top acm_checker u_acm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_result        (rsp_chan.result),
   .rsp_miss          (rsp_chan.miss),
   .rsp_alphabet_size (rsp_chan.alphabet_size)
);

`default_nettype wire
